[rtl/girv_pkg.sv]
// ----------------------------------------------------------------------------
// girv_pkg
// Shared widths, request codes and the pipeline item record of the grid
// index ravel / unravel block.
// ----------------------------------------------------------------------------
`default_nettype none

package girv_pkg;

   localparam int unsigned PORT_DIMS  = 4;
   localparam int unsigned MAX_DIMS   = 4;
   localparam int unsigned COORD_BITS = 12;

   localparam int unsigned COORD_W  = COORD_BITS;
   localparam int unsigned INDEX_W  = 48;
   localparam int unsigned EXT_W    = COORD_BITS + 1;
   localparam int unsigned NDIMS_W  = 3;
   // largest stride is the product of all extents but the first
   localparam int unsigned STRIDE_W = (PORT_DIMS - 1) * COORD_BITS + 1;
   localparam int unsigned TOTAL_W  = PORT_DIMS * COORD_BITS + 1;

   localparam logic REQ_RAVEL   = 1'b0;
   localparam logic REQ_UNRAVEL = 1'b1;

   typedef struct packed {
      logic                               err;
      logic                               kind;
      logic [INDEX_W-1:0]                 index;
      logic [PORT_DIMS-1:0][COORD_W-1:0]  coord;
   } item_type;

endpackage

`default_nettype wire

[rtl/grid_index_ravel_unravel.sv]
// ----------------------------------------------------------------------------
// grid_index_ravel_unravel
// Row-major conversion between grid coordinates and a linear index, with
// bounds checking, for up to four dimensions.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): req_type 0 turns req_coord_in_* into a linear
//    index, req_type 1 turns req_index_in back into coordinates.
//  - Response channel (rsp_*): one response per request, in request order.
//    rsp_out_of_range flags a coordinate or index outside the grid; all other
//    response fields are then zero.
//  - Register port (APB style, pready tied high): num_dims at 0x00,
//    extent_0..extent_3 at 0x04..0x10. Write registers only while no request
//    is in flight; after a write, the derived strides settle through the
//    effective extent, product and stride registers. Throughput: one request
//    per cycle while the skid entry is empty, through six setup stages and
//    the three 12-stage restoring dividers (one quotient bit per stage).
//  - Reset: clears the pipeline and loads num_dims = 1 and all extents = 1.
//    req_ready is low while reset is high.
//  - Stall: the output register plus a one-entry skid buffer absorb a held
//    rsp_ready; the pipeline freezes as a whole once the skid entry is full
//    and req_ready drops until the skid drains.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_index_ravel_unravel (
   input  wire                                 clock,
   input  wire                                 reset,

   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_type,
   input  wire  [girv_pkg::COORD_W-1:0]        req_coord_in_0,
   input  wire  [girv_pkg::COORD_W-1:0]        req_coord_in_1,
   input  wire  [girv_pkg::COORD_W-1:0]        req_coord_in_2,
   input  wire  [girv_pkg::COORD_W-1:0]        req_coord_in_3,
   input  wire  [girv_pkg::INDEX_W-1:0]        req_index_in,

   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_out_of_range,
   output logic [girv_pkg::INDEX_W-1:0]        rsp_index_out,
   output logic [girv_pkg::COORD_W-1:0]        rsp_coord_out_0,
   output logic [girv_pkg::COORD_W-1:0]        rsp_coord_out_1,
   output logic [girv_pkg::COORD_W-1:0]        rsp_coord_out_2,
   output logic [girv_pkg::COORD_W-1:0]        rsp_coord_out_3,

   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [4:0]                          paddr,
   input  wire  [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int unsigned DIMS     = girv_pkg::PORT_DIMS;
   localparam int unsigned CW       = girv_pkg::COORD_W;
   localparam int unsigned IW       = girv_pkg::INDEX_W;
   localparam int unsigned XW       = girv_pkg::EXT_W;
   localparam int unsigned NW       = girv_pkg::NDIMS_W;
   localparam int unsigned SW       = girv_pkg::STRIDE_W;
   localparam int unsigned TW       = girv_pkg::TOTAL_W;
   localparam int unsigned PAIR_W   = 2 * XW;
   localparam int unsigned TRIPLE_W = 3 * XW;
   localparam int unsigned QUAD_W   = 4 * XW;
   localparam int unsigned MUL_W    = CW + SW;
   localparam int unsigned RIDX_W   = 3;

   localparam logic [RIDX_W-1:0] REG_NUM_DIMS = 3'd0;
   localparam logic [RIDX_W-1:0] REG_EXTENT_0 = 3'd1;
   localparam logic [RIDX_W-1:0] REG_EXTENT_1 = 3'd2;
   localparam logic [RIDX_W-1:0] REG_EXTENT_2 = 3'd3;
   localparam logic [RIDX_W-1:0] REG_EXTENT_3 = 3'd4;

   localparam logic [XW-1:0] EXT_CAP = XW'(1) << girv_pkg::COORD_BITS;

   // ------------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------------
   logic [NW-1:0]     num_dims_ff;
   logic [XW-1:0]     extent_ff [DIMS];
   logic [RIDX_W-1:0] reg_idx;
   logic              reg_wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign reg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff <= NW'(1);
         for (int d = 0; d < DIMS; d++) begin
            extent_ff[d] <= XW'(1);
         end
      end else if (reg_wr) begin
         unique case (reg_idx)
            REG_NUM_DIMS: num_dims_ff  <= pwdata[NW-1:0];
            REG_EXTENT_0: extent_ff[0] <= pwdata[XW-1:0];
            REG_EXTENT_1: extent_ff[1] <= pwdata[XW-1:0];
            REG_EXTENT_2: extent_ff[2] <= pwdata[XW-1:0];
            REG_EXTENT_3: extent_ff[3] <= pwdata[XW-1:0];
            default: ;  // drop writes past the register list
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_NUM_DIMS: prdata = 32'(num_dims_ff);
         REG_EXTENT_0: prdata = 32'(extent_ff[0]);
         REG_EXTENT_1: prdata = 32'(extent_ff[1]);
         REG_EXTENT_2: prdata = 32'(extent_ff[2]);
         REG_EXTENT_3: prdata = 32'(extent_ff[3]);
         default:      prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Derived grid shape: effective extents, strides and grid size.
   // Unused dimensions count as extent 1, so every stride formula is uniform.
   // ------------------------------------------------------------------------
   logic [NW-1:0]     n_used;
   logic              used_ff  [DIMS];
   logic [XW-1:0]     ext_ff   [DIMS];
   logic [PAIR_W-1:0] p01_ff;
   logic [PAIR_W-1:0] p23_ff;
   logic [XW-1:0]     e1_ff;
   logic [XW-1:0]     e3_ff;
   logic [SW-1:0]     stride_ff [DIMS];
   logic [TW-1:0]     total_ff;

   always_comb begin
      n_used = num_dims_ff;
      if (num_dims_ff == '0) begin
         n_used = NW'(1);
      end else if (num_dims_ff > NW'(girv_pkg::MAX_DIMS)) begin
         n_used = NW'(girv_pkg::MAX_DIMS);
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < DIMS; d++) begin
         used_ff[d] <= (NW'(d) < n_used);
         if (NW'(d) >= n_used) begin
            ext_ff[d] <= XW'(1);
         end else if (extent_ff[d] > EXT_CAP) begin
            ext_ff[d] <= EXT_CAP;
         end else begin
            ext_ff[d] <= extent_ff[d];
         end
      end
      p01_ff <= PAIR_W'(ext_ff[0]) * PAIR_W'(ext_ff[1]);
      p23_ff <= PAIR_W'(ext_ff[2]) * PAIR_W'(ext_ff[3]);
      e1_ff  <= ext_ff[1];
      e3_ff  <= ext_ff[3];
      stride_ff[0] <= SW'(TRIPLE_W'(e1_ff) * TRIPLE_W'(p23_ff));
      stride_ff[1] <= SW'(p23_ff);
      stride_ff[2] <= SW'(e3_ff);
      stride_ff[3] <= SW'(1);
      total_ff     <= TW'(QUAD_W'(p01_ff) * QUAD_W'(p23_ff));
   end

   // ------------------------------------------------------------------------
   // Pipeline control: the whole pipe advances unless the skid entry is full.
   // ------------------------------------------------------------------------
   logic               en;
   logic               out_valid_ff;
   logic               skid_valid_ff;
   girv_pkg::item_type out_ff;
   girv_pkg::item_type skid_ff;

   assign en        = !skid_valid_ff;
   assign req_ready = en && !reset;

   // ------------------------------------------------------------------------
   // Stage 1: capture the request
   // ------------------------------------------------------------------------
   logic          s1_valid_ff;
   logic          s1_kind_ff;
   logic [CW-1:0] s1_coord_ff [DIMS];
   logic [IW-1:0] s1_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff     <= req_type;
         s1_coord_ff[0] <= req_coord_in_0;
         s1_coord_ff[1] <= req_coord_in_1;
         s1_coord_ff[2] <= req_coord_in_2;
         s1_coord_ff[3] <= req_coord_in_3;
         s1_rem_ff      <= req_index_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: zero unused coordinates, bounds-check forward requests
   // ------------------------------------------------------------------------
   logic          s2_valid_ff;
   logic          s2_kind_ff;
   logic          s2_err_ff;
   logic [CW-1:0] s2_coord_ff [DIMS];
   logic [IW-1:0] s2_rem_ff;
   logic [CW-1:0] s2_coord_in [DIMS];
   logic          s2_err_in;

   always_comb begin
      s2_err_in = 1'b0;
      for (int d = 0; d < DIMS; d++) begin
         s2_coord_in[d] = used_ff[d] ? s1_coord_ff[d] : '0;
         if (XW'(s2_coord_in[d]) >= ext_ff[d]) begin
            s2_err_in = 1'b1;
         end
      end
      if (s1_kind_ff != girv_pkg::REQ_RAVEL) begin
         s2_err_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: pass-through register stage so the strides are settled before use
   // ------------------------------------------------------------------------
   logic          s3_valid_ff;
   logic          s3_kind_ff;
   logic          s3_err_ff;
   logic [CW-1:0] s3_coord_ff [DIMS];
   logic [IW-1:0] s3_rem_ff;

   // ------------------------------------------------------------------------
   // Stage 4: coordinate times stride; bounds-check inverse requests
   // ------------------------------------------------------------------------
   logic          s4_valid_ff;
   logic          s4_kind_ff;
   logic          s4_err_ff;
   logic [IW-1:0] s4_term_ff [DIMS];
   logic [IW-1:0] s4_rem_ff;

   // ------------------------------------------------------------------------
   // Stages 5 and 6: add the four terms as a two-level tree
   // ------------------------------------------------------------------------
   logic          s5_valid_ff;
   logic          s5_kind_ff;
   logic          s5_err_ff;
   logic [IW-1:0] s5_sum01_ff;
   logic [IW-1:0] s5_sum23_ff;
   logic [IW-1:0] s5_rem_ff;

   logic          s6_valid_ff;
   logic          s6_kind_ff;
   logic          s6_err_ff;
   logic [IW-1:0] s6_index_ff;
   logic [IW-1:0] s6_rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_err_ff   <= s2_err_in;
         s2_coord_ff <= s2_coord_in;
         s2_rem_ff   <= s1_rem_ff;

         s3_kind_ff  <= s2_kind_ff;
         s3_err_ff   <= s2_err_ff;
         s3_coord_ff <= s2_coord_ff;
         s3_rem_ff   <= s2_rem_ff;

         s4_kind_ff  <= s3_kind_ff;
         // index at or past the grid size (or an empty grid) is out of range
         s4_err_ff   <= (s3_kind_ff == girv_pkg::REQ_UNRAVEL)
                        ? (TW'(s3_rem_ff) >= total_ff) : s3_err_ff;
         for (int d = 0; d < DIMS; d++) begin
            s4_term_ff[d] <= IW'(MUL_W'(s3_coord_ff[d]) * MUL_W'(stride_ff[d]));
         end
         s4_rem_ff   <= s3_rem_ff;

         s5_kind_ff  <= s4_kind_ff;
         s5_err_ff   <= s4_err_ff;
         s5_sum01_ff <= s4_term_ff[0] + s4_term_ff[1];
         s5_sum23_ff <= s4_term_ff[2] + s4_term_ff[3];
         s5_rem_ff   <= s4_rem_ff;

         s6_kind_ff  <= s5_kind_ff;
         s6_err_ff   <= s5_err_ff;
         s6_index_ff <= s5_sum01_ff + s5_sum23_ff;
         s6_rem_ff   <= s5_rem_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Divider chain: dimension d's coordinate is the remainder divided by its
   // stride; the last dimension's stride is 1, so it takes the final remainder.
   // ------------------------------------------------------------------------
   logic               chain_valid [DIMS];
   logic [IW-1:0]      chain_rem   [DIMS];
   girv_pkg::item_type chain_item  [DIMS];

   assign chain_valid[0] = s6_valid_ff;
   assign chain_rem[0]   = s6_rem_ff;
   assign chain_item[0]  = '{err: s6_err_ff, kind: s6_kind_ff, index: s6_index_ff,
                             coord: '0};

   for (genvar g = 0; g < DIMS - 1; g++) begin : g_div
      girv_div #(
         .DIM (g)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .divisor   (stride_ff[g]),
         .in_valid  (chain_valid[g]),
         .in_rem    (chain_rem[g]),
         .in_item   (chain_item[g]),
         .out_valid (chain_valid[g+1]),
         .out_rem   (chain_rem[g+1]),
         .out_item  (chain_item[g+1])
      );
   end

   // ------------------------------------------------------------------------
   // Result assembly: zero everything on error, keep only the fields that
   // belong to the request kind.
   // ------------------------------------------------------------------------
   girv_pkg::item_type last_item;
   girv_pkg::item_type res;
   logic               push;

   assign last_item = chain_item[DIMS-1];
   assign push      = en && chain_valid[DIMS-1];

   always_comb begin
      res      = '0;
      res.err  = last_item.err;
      res.kind = last_item.kind;
      if (!last_item.err) begin
         if (last_item.kind == girv_pkg::REQ_RAVEL) begin
            res.index = last_item.index;
         end else begin
            res.coord = last_item.coord;
            res.coord[DIMS-1] = chain_rem[DIMS-1][CW-1:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register with one-entry skid buffer
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         // output slot frees: refill from skid first, else from the pipe
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= push;
         end
      end else if (push) begin
         // output held: park the arriving response
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= res;
         end
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_of_range = out_ff.err;
   assign rsp_index_out    = out_ff.index;
   assign rsp_coord_out_0  = out_ff.coord[0];
   assign rsp_coord_out_1  = out_ff.coord[1];
   assign rsp_coord_out_2  = out_ff.coord[2];
   assign rsp_coord_out_3  = out_ff.coord[3];

endmodule

`default_nettype wire

[rtl/girv_div.sv]
// ----------------------------------------------------------------------------
// girv_div
// Pipelined restoring divider for one grid dimension: one quotient bit per
// stage, quotient written into that dimension's coordinate, remainder passed on.
// ----------------------------------------------------------------------------
`default_nettype none

module girv_div #(
   parameter int unsigned DIM = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  en,
   input  wire  [girv_pkg::STRIDE_W-1:0]        divisor,
   input  wire                                  in_valid,
   input  wire  [girv_pkg::INDEX_W-1:0]         in_rem,
   input  girv_pkg::item_type                   in_item,
   output logic                                 out_valid,
   output logic [girv_pkg::INDEX_W-1:0]         out_rem,
   output girv_pkg::item_type                   out_item
);

   localparam int unsigned STEPS = girv_pkg::COORD_W;
   localparam int unsigned RW    = girv_pkg::INDEX_W;
   localparam int unsigned CW    = girv_pkg::STRIDE_W + girv_pkg::COORD_W;

   logic [STEPS-1:0]    valid_ff;
   logic [RW-1:0]       rem_ff    [STEPS];
   girv_pkg::item_type  item_ff   [STEPS];

   logic [RW-1:0]       src_rem   [STEPS];
   girv_pkg::item_type  src_item  [STEPS];
   logic [RW-1:0]       rem_in    [STEPS];
   girv_pkg::item_type  item_in   [STEPS];

   always_comb begin
      src_rem[0]  = in_rem;
      src_item[0] = in_item;
      for (int k = 1; k < STEPS; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_item[k] = item_ff[k-1];
      end
   end

   // subtract the shifted divisor where it fits, high quotient bit first
   always_comb begin
      logic [CW-1:0] shifted;
      logic          take;
      for (int k = 0; k < STEPS; k++) begin
         shifted    = CW'(divisor) << (STEPS - 1 - k);
         take       = (CW'(src_rem[k]) >= shifted);
         item_in[k] = src_item[k];
         item_in[k].coord[DIM][STEPS-1-k] = take;
         rem_in[k]  = take ? RW'(CW'(src_rem[k]) - shifted) : src_rem[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            rem_ff[k]  <= rem_in[k];
            item_ff[k] <= item_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_rem   = rem_ff[STEPS-1];
   assign out_item  = item_ff[STEPS-1];

endmodule

`default_nettype wire
